>>> design/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg : shared types and constants of the I2C master bit engine
// Opcodes, command classes, sequencer phases and the words that pass
// between the front end, the command queue and the bit sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmbe_pkg;

   // field widths
   localparam int OP_WIDTH          = 3;
   localparam int BYTE_WIDTH        = 8;
   localparam int HALF_PERIOD_WIDTH = 16;
   localparam int POLL_LIMIT_WIDTH  = 8;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = 16;
   localparam int BIT_INDEX_WIDTH   = 4;

   // default width of the phase delay counter
   localparam int DELAY_COUNTER_WIDTH_DEF = 16;

   // reset values of the configuration registers
   localparam logic [HALF_PERIOD_WIDTH-1:0] HALF_PERIOD_RESET = 16'd5;
   localparam logic [POLL_LIMIT_WIDTH-1:0]  POLL_LIMIT_RESET  = 8'd10;

   // entries in the command queue
   localparam int QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_PERIOD    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACK_POLL_LIMIT = 1'b1;

   // opcodes
   localparam logic [OP_WIDTH-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_START = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_STOP  = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_WRITE = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_READ  = 3'd4;

   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_START,
      KIND_STOP,
      KIND_WRITE,
      KIND_READ,
      KIND_NONE
   } kind_type;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_S1,
      PH_S2,
      PH_S3,
      PH_T1,
      PH_T2,
      PH_T3,
      PH_T4,
      PH_W_LOW,
      PH_W_DATA,
      PH_W_HIGH,
      PH_W_END,
      PH_A_REL,
      PH_A_HIGH,
      PH_A_END,
      PH_R_LOW,
      PH_R_HIGH,
      PH_K_LOW,
      PH_K_DATA,
      PH_K_HIGH,
      PH_K_END
   } phase_type;

   // classified command word held in the queue
   typedef struct packed {
      kind_type              kind;
      logic [BYTE_WIDTH-1:0] write_data;
      logic                  send_ack;
      logic                  sda_in;
   } cmd_type;

   // result word
   typedef struct packed {
      logic                  scl_level;
      logic                  sda_pull_low;
      logic                  busy;
      logic                  done;
      logic                  nack_seen;
      logic [BYTE_WIDTH-1:0] read_byte;
   } result_type;

endpackage

>>> design/i2cmbe_front.sv
// ----------------------------------------------------------------------------
// i2cmbe_front : request front end
// Accepts request words and classifies the opcode into a command class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbe_front (
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [i2cmbe_pkg::OP_WIDTH-1:0]   req_op,
   input  logic [i2cmbe_pkg::BYTE_WIDTH-1:0] req_write_data,
   input  logic                              req_send_ack,
   input  logic                              req_sda_in,
   input  logic                              queue_full,
   output logic                              push,
   output i2cmbe_pkg::cmd_type               push_word
);
   import i2cmbe_pkg::*;

   kind_type kind;

   always_comb begin
      case (req_op)
         OP_TICK:  kind = KIND_TICK;
         OP_START: kind = KIND_START;
         OP_STOP:  kind = KIND_STOP;
         OP_WRITE: kind = KIND_WRITE;
         OP_READ:  kind = KIND_READ;
         default:  kind = KIND_NONE;
      endcase
   end

   assign req_stall            = queue_full;
   assign push                 = req_valid & ~queue_full;
   assign push_word.kind       = kind;
   assign push_word.write_data = req_write_data;
   assign push_word.send_ack   = req_send_ack;
   assign push_word.sda_in     = req_sda_in;

endmodule

>>> design/i2cmbe_queue.sv
// ----------------------------------------------------------------------------
// i2cmbe_queue : command queue
// Short first-in first-out store between the front end and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cmbe_pkg::cmd_type push_word,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop,
   output i2cmbe_pkg::cmd_type pop_word
);
   import i2cmbe_pkg::*;

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_pop;

   assign full      = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_word  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> design/i2cmbe_engine.sv
// ----------------------------------------------------------------------------
// i2cmbe_engine : bit sequencer
// Runs the pin phase sequence one command word at a time and registers
// one result word per command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbe_engine #(
   parameter int DELAY_COUNTER_WIDTH = i2cmbe_pkg::DELAY_COUNTER_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [i2cmbe_pkg::HALF_PERIOD_WIDTH-1:0] half_period,
   input  logic [i2cmbe_pkg::POLL_LIMIT_WIDTH-1:0]  poll_limit,
   input  logic                                     cmd_valid,
   input  i2cmbe_pkg::cmd_type                      cmd_word,
   output logic                                     cmd_pop,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output i2cmbe_pkg::result_type                   rsp_word
);
   import i2cmbe_pkg::*;

   localparam int LOAD_WIDTH = (DELAY_COUNTER_WIDTH > HALF_PERIOD_WIDTH) ?
                               DELAY_COUNTER_WIDTH : HALF_PERIOD_WIDTH;

   phase_type                      phase_ff, phase_in;
   logic [DELAY_COUNTER_WIDTH-1:0] delay_ff, delay_in;
   logic [BIT_INDEX_WIDTH-1:0]     bit_ff, bit_in;
   logic [BYTE_WIDTH-1:0]          shift_ff, shift_in;
   logic [POLL_LIMIT_WIDTH-1:0]    poll_ff, poll_in;
   logic                           ack_ff, ack_in;
   logic                           nack_ff, nack_in;
   logic                           scl_ff, scl_in;
   logic                           sda_low_ff, sda_low_in;
   logic                           done_in;
   logic                           rsp_valid_ff;
   result_type                     rsp_ff;

   logic [LOAD_WIDTH-1:0]          hp_wide, cnt_max_wide;
   logic [DELAY_COUNTER_WIDTH-1:0] delay_load;
   logic [POLL_LIMIT_WIDTH-1:0]    limit_eff, poll_next;
   logic [BIT_INDEX_WIDTH-1:0]     bit_next;
   logic                           active, expire, start_cmd, poll_hit;

   // phase delay reload: zero acts as one, saturate to the counter range
   assign hp_wide      = (half_period == '0) ? LOAD_WIDTH'(1) : LOAD_WIDTH'(half_period);
   assign cnt_max_wide = LOAD_WIDTH'({DELAY_COUNTER_WIDTH{1'b1}});
   assign delay_load   = (hp_wide > cnt_max_wide) ? DELAY_COUNTER_WIDTH'(cnt_max_wide) :
                                                    DELAY_COUNTER_WIDTH'(hp_wide);
   assign limit_eff    = (poll_limit == '0) ? POLL_LIMIT_WIDTH'(1) : poll_limit;

   // take a word whenever the result register is free or draining
   assign cmd_pop   = cmd_valid & (~rsp_valid_ff | ~rsp_stall);
   assign active    = cmd_word.kind == KIND_TICK && phase_ff != PH_IDLE;
   assign expire    = active && delay_ff <= DELAY_COUNTER_WIDTH'(1);
   assign start_cmd = cmd_word.kind != KIND_TICK && phase_ff == PH_IDLE;
   assign bit_next  = bit_ff + 1'b1;
   assign poll_next = poll_ff + 1'b1;
   assign poll_hit  = poll_next >= limit_eff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (cmd_pop) begin
         if (expire) begin
            case (phase_ff)
               PH_S1:     phase_in = PH_S2;
               PH_S2:     phase_in = PH_S3;
               PH_T1:     phase_in = PH_T2;
               PH_T2:     phase_in = PH_T3;
               PH_T3:     phase_in = PH_T4;
               PH_W_LOW:  phase_in = PH_W_DATA;
               PH_W_DATA: phase_in = PH_W_HIGH;
               PH_W_HIGH: phase_in = (bit_next < BIT_INDEX_WIDTH'(8)) ? PH_W_LOW : PH_W_END;
               PH_W_END:  phase_in = PH_A_REL;
               PH_A_REL:  phase_in = PH_A_HIGH;
               PH_A_HIGH: phase_in = (!cmd_word.sda_in || poll_hit) ? PH_A_END : PH_A_HIGH;
               PH_R_LOW:  phase_in = PH_R_HIGH;
               PH_R_HIGH: phase_in = (bit_next < BIT_INDEX_WIDTH'(8)) ? PH_R_LOW : PH_K_LOW;
               PH_K_LOW:  phase_in = PH_K_DATA;
               PH_K_DATA: phase_in = PH_K_HIGH;
               PH_K_HIGH: phase_in = PH_K_END;
               default:   phase_in = PH_IDLE;
            endcase
         end else if (start_cmd) begin
            case (cmd_word.kind)
               KIND_START: phase_in = PH_S1;
               KIND_STOP:  phase_in = PH_T1;
               KIND_WRITE: phase_in = PH_W_LOW;
               KIND_READ:  phase_in = PH_R_LOW;
               default:    phase_in = phase_ff;
            endcase
         end
      end
   end

   // pins, counters and shift register
   always_comb begin
      delay_in   = delay_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      poll_in    = poll_ff;
      ack_in     = ack_ff;
      nack_in    = nack_ff;
      scl_in     = scl_ff;
      sda_low_in = sda_low_ff;
      done_in    = 1'b0;
      if (cmd_pop) begin
         if (active && !expire) begin
            delay_in = delay_ff - 1'b1;
         end else if (expire) begin
            delay_in = delay_load;
            case (phase_ff)
               PH_S1:     sda_low_in = 1'b1;
               PH_S2:     scl_in = 1'b0;
               PH_T1:     scl_in = 1'b1;
               PH_T2:     sda_low_in = 1'b0;
               PH_T3:     scl_in = 1'b0;
               PH_W_LOW:  sda_low_in = ~shift_ff[3'(7) - bit_ff[2:0]];
               PH_W_DATA: scl_in = 1'b1;
               PH_W_HIGH: begin
                  bit_in = bit_next;
                  scl_in = 1'b0;
               end
               PH_W_END:  sda_low_in = 1'b0;
               PH_A_REL: begin
                  scl_in  = 1'b1;
                  poll_in = '0;
               end
               PH_A_HIGH: begin
                  if (!cmd_word.sda_in) begin
                     nack_in = 1'b0;
                     scl_in  = 1'b0;
                  end else begin
                     poll_in = poll_next;
                     if (poll_hit) begin
                        nack_in = 1'b1;
                        scl_in  = 1'b0;
                     end
                  end
               end
               PH_R_LOW:  scl_in = 1'b1;
               PH_R_HIGH: begin
                  shift_in = {shift_ff[BYTE_WIDTH-2:0], cmd_word.sda_in};
                  bit_in   = bit_next;
                  scl_in   = 1'b0;
               end
               PH_K_LOW:  sda_low_in = ack_ff;
               PH_K_DATA: scl_in = 1'b1;
               PH_K_HIGH: scl_in = 1'b0;
               default: begin
                  delay_in = '0;
                  done_in  = 1'b1;
               end
            endcase
         end else if (start_cmd) begin
            case (cmd_word.kind)
               KIND_START: begin
                  delay_in   = delay_load;
                  scl_in     = 1'b1;
                  sda_low_in = 1'b0;
               end
               KIND_STOP: begin
                  delay_in   = delay_load;
                  sda_low_in = 1'b1;
               end
               KIND_WRITE: begin
                  delay_in = delay_load;
                  shift_in = cmd_word.write_data;
                  bit_in   = '0;
                  nack_in  = 1'b0;
                  scl_in   = 1'b0;
               end
               KIND_READ: begin
                  delay_in   = delay_load;
                  shift_in   = '0;
                  bit_in     = '0;
                  ack_in     = cmd_word.send_ack;
                  scl_in     = 1'b0;
                  sda_low_in = 1'b0;
               end
               default: delay_in = delay_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         delay_ff     <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         poll_ff      <= '0;
         ack_ff       <= 1'b0;
         nack_ff      <= 1'b0;
         scl_ff       <= 1'b0;
         sda_low_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         delay_ff   <= delay_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         poll_ff    <= poll_in;
         ack_ff     <= ack_in;
         nack_ff    <= nack_in;
         scl_ff     <= scl_in;
         sda_low_ff <= sda_low_in;
         if (cmd_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result register, loaded with the state after this word
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_ff.scl_level    <= scl_in;
         rsp_ff.sda_pull_low <= sda_low_in;
         rsp_ff.busy         <= (phase_in != PH_IDLE);
         rsp_ff.done         <= done_in;
         rsp_ff.nack_seen    <= nack_in;
         rsp_ff.read_byte    <= shift_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

>>> design/i2c_master_bit_engine.sv
// An accepted request word is written into the command queue; its result word is then registered by the bit sequencer.
// Throughput: one word per cycle while the result side does not stall; the bit sequencer advances at most one pin
// phase per word and the two-entry command queue absorbs a stalled result side.
// Reset (synchronous, active high): sequencer idle, SCL low, SDA pulled low,
// queue and result register empty, half period 5, acknowledge poll limit 10.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine : I2C master bit engine, top level
// Holds the configuration registers and ties the request front end, the
// command queue and the bit sequencer together.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_engine #(
   parameter int DELAY_COUNTER_WIDTH = i2cmbe_pkg::DELAY_COUNTER_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration write port
   input  logic                                   csr_write_enable,
   input  logic [i2cmbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cmbe_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [i2cmbe_pkg::OP_WIDTH-1:0]        req_op,
   input  logic [i2cmbe_pkg::BYTE_WIDTH-1:0]      req_write_data,
   input  logic                                   req_send_ack,
   input  logic                                   req_sda_in,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_scl_level,
   output logic                                   rsp_sda_pull_low,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_done_res,
   output logic                                   rsp_nack_seen,
   output logic [i2cmbe_pkg::BYTE_WIDTH-1:0]      rsp_read_byte
);
   import i2cmbe_pkg::*;

   logic [HALF_PERIOD_WIDTH-1:0] half_period_ff;
   logic [POLL_LIMIT_WIDTH-1:0]  poll_limit_ff;

   logic       push, queue_full, cmd_valid, cmd_pop;
   cmd_type    push_word, cmd_word;
   result_type rsp_word;

   // configuration registers; written by the user only while the engine is idle, not enforced by the block
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         poll_limit_ff  <= POLL_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HALF_PERIOD:    half_period_ff <= csr_write_data[HALF_PERIOD_WIDTH-1:0];
            CSR_ACK_POLL_LIMIT: poll_limit_ff  <= csr_write_data[POLL_LIMIT_WIDTH-1:0];
            default: begin
               half_period_ff <= half_period_ff;
            end
         endcase
      end
   end

   // accept and classify request words
   i2cmbe_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_write_data (req_write_data),
      .req_send_ack   (req_send_ack),
      .req_sda_in     (req_sda_in),
      .queue_full     (queue_full),
      .push           (push),
      .push_word      (push_word)
   );

   // decouple the front end from the sequencer
   i2cmbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop_valid (cmd_valid),
      .pop       (cmd_pop),
      .pop_word  (cmd_word)
   );

   // run the pin phases and register the result word
   i2cmbe_engine #(
      .DELAY_COUNTER_WIDTH (DELAY_COUNTER_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_period_ff),
      .poll_limit  (poll_limit_ff),
      .cmd_valid   (cmd_valid),
      .cmd_word    (cmd_word),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

   assign rsp_scl_level    = rsp_word.scl_level;
   assign rsp_sda_pull_low = rsp_word.sda_pull_low;
   assign rsp_busy_res     = rsp_word.busy;
   assign rsp_done_res     = rsp_word.done;
   assign rsp_nack_seen    = rsp_word.nack_seen;
   assign rsp_read_byte    = rsp_word.read_byte;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for the I2C master bit engine
// Drives command and tick words through the request channel with random
// gaps and result-side stalls. A bit-accurate model of the pin sequencer
// predicts every result word, and each word is compared field by field.
// ----------------------------------------------------------------------------

module tb;
   import i2cmbe_pkg::*;

   // unassigned opcodes; the engine must ignore them
   localparam logic [OP_WIDTH-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_SPARE_LAST  = 3'd7;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_TAIL  = 8;
   localparam int IDLE_PCT    = 28;

   // pin state straight after reset, and right after a start command
   localparam result_type RESET_WORD = '{scl_level: 1'b0, sda_pull_low: 1'b1, busy: 1'b0,
                                         done: 1'b0, nack_seen: 1'b0, read_byte: 8'h00};
   localparam result_type START_WORD = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy: 1'b1,
                                         done: 1'b0, nack_seen: 1'b0, read_byte: 8'h00};

   // one row of the directed table: a word sent reps times in a row
   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [BYTE_WIDTH-1:0] data;
      logic                  send_ack;
      logic                  sda;
      logic [7:0]            reps;
      logic                  typed;
      result_type            want;
   } stim_row_type;

   localparam int DIR_ROWS = 17;

   logic clock;
   logic reset            = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;
   logic req_valid        = 1'b0;
   logic req_stall;
   logic [OP_WIDTH-1:0]   req_op         = OP_TICK;
   logic [BYTE_WIDTH-1:0] req_write_data = '0;
   logic req_send_ack     = 1'b0;
   logic req_sda_in       = 1'b0;
   logic rsp_valid;
   logic rsp_stall        = 1'b0;
   logic rsp_scl_level;
   logic rsp_sda_pull_low;
   logic rsp_busy_res;
   logic rsp_done_res;
   logic rsp_nack_seen;
   logic [BYTE_WIDTH-1:0] rsp_read_byte;

   i2c_master_bit_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_write_data   (req_write_data),
      .req_send_ack     (req_send_ack),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_nack_seen    (rsp_nack_seen),
      .rsp_read_byte    (rsp_read_byte)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Bench state
   // --------------------------------------------------------------------------
   result_type   pin_words_due [$];   // predicted result words, oldest first
   stim_row_type dir_rows [0:DIR_ROWS-1];
   bit           idle_on = 1'b1;      // clear for the stretch with no gaps or stalls
   int           errors = 0;
   int           words_sent = 0;
   int           words_checked = 0;
   int           settings_used = 0;
   int           cycles = 0;
   int           slave_ack_after = 0; // high samples the slave lets pass before ACK
   result_type   seen_word;
   result_type   due_word;

   // sequencer copy and its configuration
   logic [HALF_PERIOD_WIDTH-1:0] cfg_half;
   logic [POLL_LIMIT_WIDTH-1:0]  cfg_limit;
   phase_type                    seq_phase;
   int unsigned                  seq_delay;
   logic [BIT_INDEX_WIDTH-1:0]   seq_bit;
   logic [BYTE_WIDTH-1:0]        seq_shift;
   logic [POLL_LIMIT_WIDTH-1:0]  seq_polls;
   logic                         seq_ack_choice;
   logic                         seq_nack;
   logic                         seq_scl;
   logic                         seq_sda_low;

   initial begin
      cfg_half       = HALF_PERIOD_RESET;
      cfg_limit      = POLL_LIMIT_RESET;
      seq_phase      = PH_IDLE;
      seq_delay      = 0;
      seq_bit        = '0;
      seq_shift      = '0;
      seq_polls      = '0;
      seq_ack_choice = 1'b0;
      seq_nack       = 1'b0;
      seq_scl        = 1'b0;
      seq_sda_low    = 1'b1;
   end

   // --------------------------------------------------------------------------
   // Sequencer prediction
   // --------------------------------------------------------------------------

   // Enter a phase and load the half-period delay; zero acts as one and the
   // value saturates at the top of the delay counter.
   function void enter_phase(input phase_type nxt);
      longint unsigned ceiling;
      longint unsigned span;
      ceiling = (64'd1 << DELAY_COUNTER_WIDTH_DEF) - 1;
      span    = (cfg_half == '0) ? 1 : cfg_half;
      if (span > ceiling)
         span = ceiling;
      seq_phase = nxt;
      seq_delay = 32'(span);
   endfunction

   // Delay ran out: apply the next pin phase. Return 1 once the sequence ends.
   function logic next_pin_phase(input logic sda);
      int unsigned lim;
      logic        finished;
      lim      = (cfg_limit == '0) ? 1 : cfg_limit;
      finished = 1'b0;
      case (seq_phase)
         PH_S1: begin
            seq_sda_low = 1'b1;
            enter_phase(PH_S2);
         end
         PH_S2: begin
            seq_scl = 1'b0;
            enter_phase(PH_S3);
         end
         PH_T1: begin
            seq_scl = 1'b1;
            enter_phase(PH_T2);
         end
         PH_T2: begin
            seq_sda_low = 1'b0;
            enter_phase(PH_T3);
         end
         PH_T3: begin
            seq_scl = 1'b0;
            enter_phase(PH_T4);
         end
         PH_W_LOW: begin
            seq_sda_low = ~seq_shift[3'd7 - seq_bit[2:0]];
            enter_phase(PH_W_DATA);
         end
         PH_W_DATA: begin
            seq_scl = 1'b1;
            enter_phase(PH_W_HIGH);
         end
         PH_W_HIGH: begin
            seq_bit = seq_bit + 1'b1;
            seq_scl = 1'b0;
            enter_phase(seq_bit < 4'd8 ? PH_W_LOW : PH_W_END);
         end
         PH_W_END: begin
            seq_sda_low = 1'b0;
            enter_phase(PH_A_REL);
         end
         PH_A_REL: begin
            seq_scl   = 1'b1;
            seq_polls = '0;
            enter_phase(PH_A_HIGH);
         end
         PH_A_HIGH: begin
            if (sda == 1'b0) begin
               seq_nack = 1'b0;
               seq_scl  = 1'b0;
               enter_phase(PH_A_END);
            end else begin
               seq_polls = seq_polls + 1'b1;
               if (seq_polls >= lim) begin
                  seq_nack = 1'b1;
                  seq_scl  = 1'b0;
                  enter_phase(PH_A_END);
               end else begin
                  enter_phase(PH_A_HIGH);
               end
            end
         end
         PH_R_LOW: begin
            seq_scl = 1'b1;
            enter_phase(PH_R_HIGH);
         end
         PH_R_HIGH: begin
            seq_shift = {seq_shift[6:0], sda};
            seq_bit   = seq_bit + 1'b1;
            seq_scl   = 1'b0;
            enter_phase(seq_bit < 4'd8 ? PH_R_LOW : PH_K_LOW);
         end
         PH_K_LOW: begin
            seq_sda_low = seq_ack_choice;
            enter_phase(PH_K_DATA);
         end
         PH_K_DATA: begin
            seq_scl = 1'b1;
            enter_phase(PH_K_HIGH);
         end
         PH_K_HIGH: begin
            seq_scl = 1'b0;
            enter_phase(PH_K_END);
         end
         default: begin
            seq_phase = PH_IDLE;
            seq_delay = 0;
            finished  = 1'b1;
         end
      endcase
      return finished;
   endfunction

   // Advance the sequencer copy by one request word and return the pin word.
   function result_type pin_word_for(input logic [OP_WIDTH-1:0] op,
                                     input logic [BYTE_WIDTH-1:0] data,
                                     input logic send_ack,
                                     input logic sda);
      logic       finished;
      result_type word;
      finished = 1'b0;
      if (op == OP_TICK) begin
         if (seq_phase != PH_IDLE) begin
            if (seq_delay > 1)
               seq_delay--;
            else
               finished = next_pin_phase(sda);
         end
      end else if (seq_phase == PH_IDLE) begin
         case (op)
            OP_START: begin
               seq_scl     = 1'b1;
               seq_sda_low = 1'b0;
               enter_phase(PH_S1);
            end
            OP_STOP: begin
               seq_sda_low = 1'b1;
               enter_phase(PH_T1);
            end
            OP_WRITE: begin
               seq_shift = data;
               seq_bit   = '0;
               seq_nack  = 1'b0;
               seq_scl   = 1'b0;
               enter_phase(PH_W_LOW);
            end
            OP_READ: begin
               seq_shift      = '0;
               seq_bit        = '0;
               seq_ack_choice = send_ack;
               seq_scl        = 1'b0;
               seq_sda_low    = 1'b0;
               enter_phase(PH_R_LOW);
            end
            default: ;   // spare opcodes change nothing
         endcase
      end
      word.scl_level    = seq_scl;
      word.sda_pull_low = seq_sda_low;
      word.busy         = (seq_phase != PH_IDLE);
      word.done         = finished;
      word.nack_seen    = seq_nack;
      word.read_byte    = seq_shift;
      return word;
   endfunction

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------

   // Offer one word, hold it until taken, then record the predicted result.
   task automatic send_word(input logic [OP_WIDTH-1:0] op, input logic [BYTE_WIDTH-1:0] data,
                            input logic send_ack, input logic sda,
                            input logic typed, input result_type want);
      result_type predicted;
      if (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_write_data <= data;
      req_send_ack   <= send_ack;
      req_sda_in     <= sda;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = pin_word_for(op, data, send_ack, sda);
      // a typed-in row overrides the prediction but the copy still advances
      pin_words_due.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   // Drop valid and wait until every predicted word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pin_words_due.size() != 0);
   endtask

   // Write both registers on back-to-back cycles while nothing is in flight.
   task automatic apply_settings(input logic [HALF_PERIOD_WIDTH-1:0] half,
                                 input logic [POLL_LIMIT_WIDTH-1:0] limit);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HALF_PERIOD;
      csr_write_data   <= CSR_DATA_WIDTH'(half);
      @(posedge clock);
      csr_index        <= CSR_ACK_POLL_LIMIT;
      csr_write_data   <= CSR_DATA_WIDTH'(limit);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_half  = half;
      cfg_limit = limit;
      settings_used++;
   endtask

   // Pick the SDA level for a tick. While the acknowledge is polled, play a
   // slave that acknowledges after a chosen number of high samples, with the
   // odd random level thrown in.
   function logic pick_sda();
      if (seq_phase == PH_A_HIGH && $urandom_range(9) != 0)
         return (int'(seq_polls) >= slave_ack_after) ? 1'b0 : 1'b1;
      return 1'($urandom_range(1));
   endfunction

   // Random span under one setting: mostly whole command sequences with
   // random content, salted with ignored commands and spare opcodes. Keep
   // going until the sequencer is back at idle.
   task automatic run_span(input logic [HALF_PERIOD_WIDTH-1:0] half,
                           input logic [POLL_LIMIT_WIDTH-1:0] limit, input int words);
      int                  counted;
      logic [OP_WIDTH-1:0] op;
      drain_results();
      apply_settings(half, limit);
      counted = 0;
      while (counted < words || seq_phase != PH_IDLE) begin
         if (seq_phase == PH_IDLE) begin
            if ($urandom_range(99) < 8) begin
               op = $urandom_range(1) ? OP_TICK :
                    OP_WIDTH'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            end else begin
               op = OP_WIDTH'($urandom_range(OP_START, OP_READ));
               counted++;
               if (op == OP_WRITE)
                  slave_ack_after = ($urandom_range(4) == 0) ? 300 : $urandom_range(0, 3);
            end
         end else begin
            if ($urandom_range(99) < 6) begin
               op = OP_WIDTH'($urandom_range(OP_START, OP_SPARE_LAST));
            end else begin
               op = OP_TICK;
               counted++;
            end
         end
         send_word(op, BYTE_WIDTH'($urandom_range(255)), 1'($urandom_range(1)), pick_sda(),
                   1'b0, '0);
      end
   endtask

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin
      // Directed table, run with a one-tick half period and a poll limit of 2
      dir_rows = '{
         // tick while idle: nothing moves
         '{OP_TICK,        8'h00, 1'b0, 1'b0, 8'd1,  1'b1, RESET_WORD},
         // spare opcode while idle: ignored
         '{OP_SPARE_LAST,  8'h55, 1'b1, 1'b1, 8'd1,  1'b1, RESET_WORD},
         // start: SCL high, SDA released at once
         '{OP_START,       8'hAA, 1'b0, 1'b1, 8'd1,  1'b1, START_WORD},
         // command while busy: ignored, sequence holds
         '{OP_READ,        8'hFF, 1'b1, 1'b0, 8'd1,  1'b1, START_WORD},
         '{OP_TICK,        8'h00, 1'b0, 1'b1, 8'd3,  1'b0, '0},
         // all-ones byte, slave never acknowledges: limit reached
         '{OP_WRITE,       8'hFF, 1'b0, 1'b0, 8'd1,  1'b0, '0},
         '{OP_TICK,        8'h00, 1'b0, 1'b1, 8'd32, 1'b0, '0},
         // all-zeros byte, acknowledged on the first sample
         '{OP_WRITE,       8'h00, 1'b1, 1'b1, 8'd1,  1'b0, '0},
         '{OP_TICK,        8'h00, 1'b0, 1'b1, 8'd26, 1'b0, '0},
         '{OP_TICK,        8'h00, 1'b0, 1'b0, 8'd4,  1'b0, '0},
         // read all ones, then ACK
         '{OP_READ,        8'h00, 1'b1, 1'b0, 8'd1,  1'b0, '0},
         '{OP_TICK,        8'hFF, 1'b1, 1'b1, 8'd22, 1'b0, '0},
         // read all zeros, then NACK
         '{OP_READ,        8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
         '{OP_TICK,        8'h00, 1'b0, 1'b0, 8'd22, 1'b0, '0},
         // stop condition
         '{OP_STOP,        8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
         '{OP_TICK,        8'h00, 1'b0, 1'b0, 8'd5,  1'b0, '0},
         '{OP_SPARE_FIRST, 8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0}
      };

      // Hold reset, then release it for good
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_settings(16'd1, 8'd2);
      for (int r = 0; r < DIR_ROWS; r++) begin
         repeat (dir_rows[r].reps)
            send_word(dir_rows[r].op, dir_rows[r].data, dir_rows[r].send_ack, dir_rows[r].sda,
                      dir_rows[r].typed, dir_rows[r].want);
      end

      // Random spans: zero registers, minimum, widest poll, small even values
      run_span(16'd0, 8'd0, 120);
      run_span(16'd1, 8'd1, 150);
      run_span(16'd1, 8'd255, 100);
      run_span(16'd2, 8'd4, 150);

      // A long half period, back to back with no gaps or stalls: one start
      drain_results();
      idle_on = 1'b0;
      apply_settings(16'd64, 8'd255);
      send_word(OP_START, 8'h00, 1'b0, 1'b1, 1'b0, '0);
      while (seq_phase != PH_IDLE)
         send_word(OP_TICK, BYTE_WIDTH'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'b0, '0);
      drain_results();
      idle_on = 1'b1;

      run_span(HALF_PERIOD_WIDTH'($urandom_range(1, 5)), POLL_LIMIT_WIDTH'($urandom_range(1, 12)),
               200);

      // Let the pipeline settle so a stray word would still be caught
      drain_results();
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("Sent %0d request words under %0d register settings; checked %0d result words.",
               words_sent, settings_used, words_checked);
      $display("Covered start, stop, write with ACK and NACK, read with ACK and NACK, ignored words.");
      if (errors == 0 && pin_words_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Result side: compare accepted words, then draw the next stall
   // --------------------------------------------------------------------------
   task automatic check_field(input string tag, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_word = {rsp_scl_level, rsp_sda_pull_low, rsp_busy_res, rsp_done_res,
                      rsp_nack_seen, rsp_read_byte};
         if (pin_words_due.size() == 0) begin
            $display("%0t: result word with nothing expected, actual %0h", $time, seen_word);
            errors++;
         end else begin
            due_word = pin_words_due.pop_front();
            check_field("scl_level",    8'(due_word.scl_level),    8'(seen_word.scl_level));
            check_field("sda_pull_low", 8'(due_word.sda_pull_low), 8'(seen_word.sda_pull_low));
            check_field("busy_res",     8'(due_word.busy),         8'(seen_word.busy));
            check_field("done_res",     8'(due_word.done),         8'(seen_word.done));
            check_field("nack_seen",    8'(due_word.nack_seen),    8'(seen_word.nack_seen));
            check_field("read_byte",    due_word.read_byte,        seen_word.read_byte);
            words_checked++;
         end
      end
      rsp_stall <= !reset && idle_on && ($urandom_range(99) < IDLE_PCT);
   end

   // Watchdog: end a run that hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d words outstanding", $time, cycles,
                  pin_words_due.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
